[hdl/infix_to_postfix_converter_macros.svh]
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_macros.svh
// assertion macros shared by the converter's checker
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ITOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/itop_pkg.sv]
// ---------------------------------------------------------------------------
// itop_pkg
// types, character codes and precedence helpers for the infix to postfix
// converter
// ---------------------------------------------------------------------------
package itop_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // character codes
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_NONE   = 8'h00;

  // precedence as an ordered code: 0 stands for "not an operator"
  typedef logic [1:0] prec_t;
  localparam prec_t PREC_NONE = 2'd0;
  localparam prec_t PREC_ADD  = 2'd1;
  localparam prec_t PREC_MUL  = 2'd2;
  localparam prec_t PREC_POW  = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LETTER,
    S_PUSH,
    S_READ,
    S_TEST,
    S_END_CHECK,
    S_FIN
  } state_t;

  // what the pop loop is doing for the current word
  typedef enum logic [1:0] {
    K_CLOSE,
    K_OP,
    K_FLUSH
  } kind_t;

  // one result word before it reaches the output register
  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       overflow_seen;
  } result_t;

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t p;
    case (c)
      CH_CARET:           p = PREC_POW;
      CH_STAR, CH_SLASH:  p = PREC_MUL;
      CH_PLUS, CH_MINUS:  p = PREC_ADD;
      default:            p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

endpackage

[hdl/infix_to_postfix_converter.sv]
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard converter: infix characters in, postfix characters out
//
// One character is taken per input word and the block is busy until its
// work is done. Letters pass straight through, '(' is pushed, ')' pops until
// the matching '(' and drops it, any other byte pops while the top binds
// strictly tighter and is then pushed (precedence ^ over * / over + -, all
// else lowest, so equal levels group right to left). A word with tlast set
// ends the expression: the stack is flushed, the final result carries tlast,
// and if the end word and its flush produced nothing, a single word with
// char_valid low is sent. A push onto a full stack is dropped and
// overflow_seen is raised for the rest of that expression. Every look at
// the stack top passes through a read state and then a test state, as the
// stack memory is read through a register ahead of the single compare unit.
// The output is held one word behind in a staging register so tlast can be
// placed, and a stalled output stalls the sequencer.
// ---------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itop_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input words
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,   // end_of_expr
  // result words
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [0] char_valid, [1] overflow_seen
  output logic       out_tlast   // last
);
  import itop_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  state_t          state_r, state_nxt;
  kind_t           kind_r, kind_nxt;
  logic [7:0]      char_r, char_nxt;
  logic            end_r, end_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  result_t         hold_r, hold_nxt;
  logic            hold_valid_r, hold_valid_nxt;
  result_t         out_r, out_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [7:0]      stack_mem [STACK_DEPTH];
  logic [7:0]      rd_data_r;
  logic [CNT_W-1:0] count_m1;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            mem_we;

  logic            out_free;
  logic            put_ok;
  logic            put_en;
  logic [7:0]      put_ch;
  logic            pop_cond;
  state_t          after_pop;

  // handshake and helpers
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign put_ok    = !hold_valid_r || out_free;
  assign count_m1  = count_r - CNT_W'(1);
  assign rd_addr   = count_m1[AW-1:0];
  assign wr_addr   = count_r[AW-1:0];

  // pop decision on the stack top
  always_comb begin
    case (kind_r)
      K_FLUSH: pop_cond = 1'b1;
      K_CLOSE: pop_cond = (rd_data_r != CH_LPAREN);
      K_OP:    pop_cond = (prec_of(rd_data_r) > prec_of(char_r));
      default: pop_cond = 1'b0;
    endcase
  end

  // where to go once the stack runs empty during a pop loop
  always_comb begin
    case (kind_r)
      K_FLUSH: after_pop = S_FIN;
      K_CLOSE: after_pop = S_END_CHECK;
      K_OP:    after_pop = S_PUSH;
      default: after_pop = S_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (is_letter(in_tdata)) begin
            state_nxt = S_LETTER;
          end else if (in_tdata == CH_LPAREN) begin
            state_nxt = S_PUSH;
          end else if (count_r == '0) begin
            state_nxt = (in_tdata == CH_RPAREN) ? S_END_CHECK : S_PUSH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_LETTER: begin
        if (put_ok) state_nxt = S_END_CHECK;
      end
      S_PUSH: state_nxt = S_END_CHECK;
      S_READ: state_nxt = S_TEST;
      S_TEST: begin
        if (pop_cond) begin
          if (put_ok) state_nxt = (count_r == CNT_W'(1)) ? after_pop : S_READ;
        end else if (kind_r == K_CLOSE) begin
          state_nxt = S_END_CHECK;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_END_CHECK: begin
        if (end_r) begin
          state_nxt = (count_r != '0) ? S_READ : S_FIN;
        end else if (!hold_valid_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and stack control
  always_comb begin
    kind_nxt       = kind_r;
    char_nxt       = char_r;
    end_nxt        = end_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mem_we         = 1'b0;
    put_en         = 1'b0;
    put_ch         = char_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          char_nxt = in_tdata;
          end_nxt  = in_tlast;
          kind_nxt = (in_tdata == CH_RPAREN) ? K_CLOSE : K_OP;
        end
      end
      S_LETTER: begin
        put_en = put_ok;
      end
      S_PUSH: begin
        if (count_r < CNT_W'(STACK_DEPTH)) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      S_TEST: begin
        if (pop_cond) begin
          if (put_ok) begin
            put_en    = 1'b1;
            put_ch    = rd_data_r;
            count_nxt = count_m1;
          end
        end else if (kind_r == K_CLOSE) begin
          // matching '(' is dropped
          count_nxt = count_m1;
        end
      end
      S_END_CHECK: begin
        if (end_r) begin
          kind_nxt = K_FLUSH;
        end else if (hold_valid_r && out_free) begin
          out_nxt        = hold_r;
          out_last_nxt   = 1'b0;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt        = hold_valid_r ? hold_r
                                        : result_t'{ch: CH_NONE, char_valid: 1'b0,
                                                    overflow_seen: ovf_r};
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          hold_valid_nxt = 1'b0;
          ovf_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // staging: a new result pushes the held one out
    if (put_en) begin
      if (hold_valid_r) begin
        out_nxt       = hold_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      hold_nxt       = '{ch: put_ch, char_valid: 1'b1, overflow_seen: ovf_r};
      hold_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    char_r     <= char_nxt;
    end_r      <= end_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // operator stack memory, registered read of the top entry
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[wr_addr] <= char_r;
    rd_data_r <= stack_mem[rd_addr];
  end

  // outputs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.ch;
  assign out_tuser  = {out_r.overflow_seen, out_r.char_valid};
  assign out_tlast  = out_last_r;

endmodule

[hdl/itop_checker.sv]
// ---------------------------------------------------------------------------
// itop_checker
// port-level checks for the infix to postfix converter, bound to the top
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_macros.svh"

module itop_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,  // [7:0] out_char
  input logic [1:0] out_tuser,  // [0] char_valid, [1] overflow_seen
  input logic       out_tlast   // last
);

  // a stalled result word must not change
  `ITOP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result word changed while stalled")

  // one word at a time: busy right after an accept
  `ITOP_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input taken on consecutive cycles")

  // the empty marker only closes an expression and carries no character
  `ITOP_ASSERT_IMP(a_marker_last, out_tvalid && !out_tuser[0], out_tlast && (out_tdata == 8'h00), "empty marker without tlast or with data")

endmodule

bind infix_to_postfix_converter itop_checker u_itop_checker (.*);
